FILE: rtl/gpc_pkg.sv
package gpc_pkg;

    // Sequencer command to one of the serial units
    typedef struct packed {
        logic load;
        logic step;
    } gpc_ctrl_t;

    // Smallest cell count that still counts as a filled rectangle
    localparam int MIN_RECT_CELLS = 4;

endpackage

FILE: rtl/gpc_stats.sv
module gpc_stats
    import gpc_pkg::*;
#(
    parameter int SIDE = 5,
    parameter int N = SIDE * SIDE,
    parameter int CW = $clog2(N + 1),
    parameter int XW = $clog2(SIDE + 1)
)
(
    input  logic          clk,
    input  gpc_ctrl_t     ctrl,
    input  logic [N-1:0]  mask_in,
    output logic [N-1:0]  mask,
    output logic [CW-1:0] count,
    output logic [XW-1:0] min_x,
    output logic [XW-1:0] max_x,
    output logic [XW-1:0] min_y,
    output logic [XW-1:0] max_y,
    output logic          connected
);

    logic [N-1:0]  mask_reg, mask_next;
    logic [N-1:0]  sh_reg, sh_next;
    logic [N-1:0]  reach_reg, reach_next;
    logic [XW-1:0] x_reg, x_next, y_reg, y_next;
    logic [CW-1:0] count_reg, count_next;
    logic [XW-1:0] min_x_reg, min_x_next, max_x_reg, max_x_next;
    logic [XW-1:0] min_y_reg, min_y_next, max_y_reg, max_y_next;
    logic [N-1:0]  first_col, last_col, grow;

    // Mark the left and right board edges
    always_comb
    begin
        first_col = '0;
        last_col  = '0;
        for (int y = 0; y < SIDE; y++)
        begin
            first_col[y * SIDE]            = 1'b1;
            last_col[y * SIDE + SIDE - 1]  = 1'b1;
        end
    end

    // One 4-neighbour dilation of the reached set
    assign grow = reach_reg
                | ((reach_reg << 1) & ~first_col)
                | ((reach_reg >> 1) & ~last_col)
                | (reach_reg << SIDE)
                | (reach_reg >> SIDE);

    // Walk one cell per step: count, bounding box, dilation
    always_comb
    begin
        mask_next  = mask_reg;
        sh_next    = sh_reg;
        reach_next = reach_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        count_next = count_reg;
        min_x_next = min_x_reg;
        max_x_next = max_x_reg;
        min_y_next = min_y_reg;
        max_y_next = max_y_reg;
        if (ctrl.load)
        begin
            mask_next  = mask_in;
            sh_next    = mask_in;
            reach_next = mask_in & (~mask_in + N'(1));
            x_next     = '0;
            y_next     = '0;
            count_next = '0;
            min_x_next = XW'(SIDE);
            max_x_next = '0;
            min_y_next = XW'(SIDE);
            max_y_next = '0;
        end
        else if (ctrl.step)
        begin
            sh_next    = sh_reg >> 1;
            reach_next = grow & mask_reg;
            if (sh_reg[0])
            begin
                count_next = count_reg + CW'(1);
                if (x_reg < min_x_reg) min_x_next = x_reg;
                if (x_reg > max_x_reg) max_x_next = x_reg;
                if (y_reg < min_y_reg) min_y_next = y_reg;
                if (y_reg > max_y_reg) max_y_next = y_reg;
            end
            if (x_reg == XW'(SIDE - 1))
            begin
                x_next = '0;
                y_next = y_reg + XW'(1);
            end
            else
            begin
                x_next = x_reg + XW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg  <= mask_next;
        sh_reg    <= sh_next;
        reach_reg <= reach_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        count_reg <= count_next;
        min_x_reg <= min_x_next;
        max_x_reg <= max_x_next;
        min_y_reg <= min_y_next;
        max_y_reg <= max_y_next;
    end

    assign mask      = mask_reg;
    assign count     = count_reg;
    assign min_x     = min_x_reg;
    assign max_x     = max_x_reg;
    assign min_y     = min_y_reg;
    assign max_y     = max_y_reg;
    assign connected = (reach_reg == mask_reg) && (mask_reg != '0);

endmodule

FILE: rtl/gpc_order.sv
module gpc_order
    import gpc_pkg::*;
#(
    parameter int SIDE = 5,
    parameter int N = SIDE * SIDE,
    parameter int IW = $clog2(N)
)
(
    input  logic          clk,
    input  gpc_ctrl_t     ctrl,
    input  logic [N-1:0]  mask_in,
    input  logic [IW-1:0] shift_plain,
    input  logic [IW-1:0] shift_flip,
    output logic [N-1:0]  canonical
);

    logic [N-1:0] mirror;
    logic [N-1:0] plain_reg, plain_next, flip_reg, flip_next;
    logic [N-1:0] a_reg, a_next, b_reg, b_next;
    logic         a_above_reg, a_above_next, b_above_reg, b_above_next;
    logic         less_reg, less_next;
    logic         a_bit, b_bit;

    // Reverse every row for the left-right mirror
    always_comb
    begin
        mirror = '0;
        for (int y = 0; y < SIDE; y++)
        begin
            for (int x = 0; x < SIDE; x++)
            begin
                mirror[y * SIDE + x] = mask_in[y * SIDE + SIDE - 1 - x];
            end
        end
    end

    assign a_bit = a_reg[N-1];
    assign b_bit = b_reg[N-1];

    // Load both candidates, then scan from the top cell down;
    // the lowest differing cell decides the order of the sorted lists
    always_comb
    begin
        plain_next   = plain_reg;
        flip_next    = flip_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        a_above_next = a_above_reg;
        b_above_next = b_above_reg;
        less_next    = less_reg;
        if (ctrl.load)
        begin
            plain_next   = mask_in >> shift_plain;
            flip_next    = mirror >> shift_flip;
            a_next       = mirror >> shift_flip;
            b_next       = mask_in >> shift_plain;
            a_above_next = 1'b0;
            b_above_next = 1'b0;
            less_next    = 1'b0;
        end
        else if (ctrl.step)
        begin
            a_next       = a_reg << 1;
            b_next       = b_reg << 1;
            a_above_next = a_above_reg | a_bit;
            b_above_next = b_above_reg | b_bit;
            if (a_bit != b_bit)
            begin
                less_next = a_bit ? b_above_reg : !a_above_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        plain_reg   <= plain_next;
        flip_reg    <= flip_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        a_above_reg <= a_above_next;
        b_above_reg <= b_above_next;
        less_reg    <= less_next;
    end

    assign canonical = less_reg ? flip_reg : plain_reg;

endmodule

FILE: rtl/grid_pattern_classifier_top.sv
// Channel | Valid        | Stall        | Payload
// cell    | cell_valid   | cell_stall   | cell_mask
// result  | result_valid | result_stall | canonical_mask, connected_flag,
//         |              |              | rectangle_flag, cell_count
//
// One item runs, with N = BOARD_SIDE*BOARD_SIDE (25 at side 5), through
// the accept cycle, a cell-serial stats walk of N steps, a shift cycle,
// an N step compare of the two candidates and a finish cycle.
// cell_stall is high from acceptance until the finish cycle has passed.
// A finished result waits in the output register while the next item runs;
// that item's finish waits while result_stall holds. Reset clears the top.
module grid_pattern_classifier_top
    import gpc_pkg::*;
#(
    parameter int BOARD_SIDE = 5
)
(
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       cell_valid,
    output logic                                       cell_stall,
    input  logic [BOARD_SIDE*BOARD_SIDE-1:0]           cell_mask,
    output logic                                       result_valid,
    input  logic                                       result_stall,
    output logic [BOARD_SIDE*BOARD_SIDE-1:0]           canonical_mask,
    output logic                                       connected_flag,
    output logic                                       rectangle_flag,
    output logic [$clog2(BOARD_SIDE*BOARD_SIDE+1)-1:0] cell_count
);

    localparam int N  = BOARD_SIDE * BOARD_SIDE;
    localparam int CW = $clog2(N + 1);
    localparam int XW = $clog2(BOARD_SIDE + 1);
    localparam int IW = $clog2(N);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PREP,
        ST_CMP,
        ST_FINISH
    } state_t;

    state_t        state_reg;
    logic [IW-1:0] step_reg;
    logic          result_valid_reg;
    logic [N-1:0]  canonical_reg;
    logic          connected_reg, rectangle_reg;
    logic [CW-1:0] count_reg;

    gpc_ctrl_t     stats_ctrl, order_ctrl;
    logic [N-1:0]  st_mask, canon;
    logic [CW-1:0] st_count;
    logic [XW-1:0] st_min_x, st_max_x, st_min_y, st_max_y;
    logic          st_connected;
    logic [IW-1:0] shift_plain, shift_flip;
    logic          accept, last_step, out_free, is_rect;

    assign accept    = cell_valid && !cell_stall;
    assign last_step = (step_reg == IW'(N - 1));
    assign out_free  = !result_valid_reg || !result_stall;

    // Drive the serial units from the sequencer state
    assign stats_ctrl.load = accept;
    assign stats_ctrl.step = (state_reg == ST_SCAN);
    assign order_ctrl.load = (state_reg == ST_PREP);
    assign order_ctrl.step = (state_reg == ST_CMP);

    // Offsets that bring each candidate to the origin
    assign shift_plain = IW'(int'(st_min_y) * BOARD_SIDE + int'(st_min_x));
    assign shift_flip  = IW'(int'(st_min_y) * BOARD_SIDE
                             + (BOARD_SIDE - 1 - int'(st_max_x)));

    // Filled bounding box of at least four cells
    assign is_rect = (int'(st_count) >= MIN_RECT_CELLS)
        && ((int'(st_max_x) - int'(st_min_x) + 1) * (int'(st_max_y) - int'(st_min_y) + 1)
            == int'(st_count));

    gpc_stats #(
        .SIDE (BOARD_SIDE)
    ) u_stats (
        .clk       (clk),
        .ctrl      (stats_ctrl),
        .mask_in   (cell_mask),
        .mask      (st_mask),
        .count     (st_count),
        .min_x     (st_min_x),
        .max_x     (st_max_x),
        .min_y     (st_min_y),
        .max_y     (st_max_y),
        .connected (st_connected)
    );

    gpc_order #(
        .SIDE (BOARD_SIDE)
    ) u_order (
        .clk         (clk),
        .ctrl        (order_ctrl),
        .mask_in     (st_mask),
        .shift_plain (shift_plain),
        .shift_flip  (shift_flip),
        .canonical   (canon)
    );

    // Sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= '0;
            result_valid_reg <= 1'b0;
            canonical_reg    <= '0;
            connected_reg    <= 1'b0;
            rectangle_reg    <= 1'b0;
            count_reg        <= '0;
        end
        else
        begin
            // Load a finished result, or drop the one just taken
            if (state_reg == ST_FINISH && out_free)
            begin
                result_valid_reg <= 1'b1;
                canonical_reg    <= canon;
                connected_reg    <= st_connected;
                rectangle_reg    <= is_rect;
                count_reg        <= st_count;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    step_reg <= '0;
                    if (accept)
                    begin
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (last_step)
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_PREP;
                    end
                    else
                    begin
                        step_reg <= step_reg + IW'(1);
                    end
                end
                ST_PREP:
                begin
                    step_reg  <= '0;
                    state_reg <= ST_CMP;
                end
                ST_CMP:
                begin
                    if (last_step)
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        step_reg <= step_reg + IW'(1);
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign cell_stall     = (state_reg != ST_IDLE);
    assign result_valid   = result_valid_reg;
    assign canonical_mask = canonical_reg;
    assign connected_flag = connected_reg;
    assign rectangle_flag = rectangle_reg;
    assign cell_count     = count_reg;

endmodule
